// File: hw/rtl/acis_pkg.sv
// shared types, constants and character helpers for the ascii integer scanner
package acis_pkg;

   // item and register widths
   localparam int CHAR_W       = 8;
   localparam int VALUE_W      = 64;
   localparam int CONSUMED_W   = 16;
   localparam int MODE_W       = 3;
   localparam int FWIDTH_W     = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int BASE_W       = 5;
   localparam int DIGIT_W      = 6;
   localparam int COUNT_BITS_DEFAULT = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MODE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPACE_CNT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPACE_SIGN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NEG_HEXOCT = 3'd4;

   // conversion modes
   localparam logic [MODE_W-1:0] MODE_SIGNED_DEC   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_AUTO         = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OCTAL        = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UNSIGNED_DEC = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HEX          = 3'd4;

   // bases, zero means "not decided yet"
   localparam logic [BASE_W-1:0] BASE_NONE = 5'd0;
   localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

   // characters
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

   // digit code for anything that is no digit in any base
   localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

   // configuration registers as seen by the parser
   typedef struct packed {
      logic [MODE_W-1:0]   conversion_mode;
      logic [FWIDTH_W-1:0] field_width;
      logic                space_counts_in_width;
      logic                allow_space_after_sign;
      logic                allow_negative_hex_octal;
   } acis_cfg_type;

   // space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
   endfunction

   // digit value in base 36, DIGIT_NONE otherwise
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] v;
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h5a) begin
         v = c - 8'h41 + 8'd10;
      end else begin
         v = {2'b00, DIGIT_NONE};
      end
      return v[DIGIT_W-1:0];
   endfunction

   // base implied by the conversion mode
   function automatic logic [BASE_W-1:0] mode_base(input logic [MODE_W-1:0] m);
      logic [BASE_W-1:0] b;
      case (m)
         MODE_SIGNED_DEC, MODE_UNSIGNED_DEC: b = BASE_DEC;
         MODE_OCTAL:                         b = BASE_OCT;
         MODE_HEX:                           b = BASE_HEX;
         default:                            b = BASE_NONE;
      endcase
      return b;
   endfunction

endpackage

// File: hw/rtl/acis_cfg_regs.sv
// configuration registers of the ascii integer scanner
module acis_cfg_regs
   import acis_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output acis_cfg_type           cfg
);

   acis_cfg_type cfg_ff;
   acis_cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE:       cfg_in.conversion_mode = csr_wdata[MODE_W-1:0];
            REG_WIDTH:      cfg_in.field_width = csr_wdata[FWIDTH_W-1:0];
            REG_SPACE_CNT:  cfg_in.space_counts_in_width = csr_wdata[0];
            REG_SPACE_SIGN: cfg_in.allow_space_after_sign = csr_wdata[0];
            REG_NEG_HEXOCT: cfg_in.allow_negative_hex_octal = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/acis_parse.sv
// parse state, per-character next-state logic and result register
module acis_parse
   import acis_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  acis_cfg_type          cfg,
   input  logic                  step,
   input  logic [CHAR_W-1:0]     character,
   input  logic                  last,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output logic [VALUE_W-1:0]    rsp_value,
   output logic [CONSUMED_W-1:0] rsp_count,
   output logic                  rsp_success
);

   localparam int CMP_W = (COUNT_BITS > FWIDTH_W) ? COUNT_BITS : FWIDTH_W;
   localparam int MAC_W = VALUE_W + 5;

   typedef enum logic [2:0] {
      PH_WS        = 3'd0,
      PH_POST_SIGN = 3'd1,
      PH_LEAD      = 3'd2,
      PH_PREFIX    = 3'd3,
      PH_ZERO      = 3'd4,
      PH_X         = 3'd5,
      PH_DIGITS    = 3'd6,
      PH_DONE      = 3'd7
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic                   inner_neg_ff, inner_neg_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [VALUE_W-1:0]     acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [FWIDTH_W-1:0]    width_left_ff, width_left_in;
   logic                   failed_ff, failed_in;
   logic                   limited_ff, limited_in;

   logic                   rsp_valid_ff;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [CONSUMED_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                   rsp_success_ff, rsp_success_in;

   logic                   stop;
   logic [1:0]             bumps;
   logic [BASE_W-1:0]      pbase;
   logic [DIGIT_W-1:0]     dig;
   logic [CMP_W-1:0]       fw_ext, cnt_ext, room;
   logic [MAC_W-1:0]       mac;
   logic [COUNT_BITS:0]    count_sum;
   logic                   bad_sign;
   logic                   ok;
   logic [CMP_W-1:0]       count_out_ext;

   assign fw_ext  = CMP_W'(cfg.field_width);
   assign cnt_ext = CMP_W'(count_ff);
   assign room    = (fw_ext > cnt_ext) ? (fw_ext - cnt_ext) : '0;
   assign dig     = digit_of(character);
   assign pbase   = mode_base(cfg.conversion_mode);

   // advance the parse by one character
   always_comb begin
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      inner_neg_in  = inner_neg_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      digit_seen_in = digit_seen_ff;
      width_left_in = width_left_ff;
      failed_in     = failed_ff;
      limited_in    = limited_ff;
      bumps         = 2'd0;
      stop          = 1'b0;
      mac           = '0;
      if (phase_ff != PH_DONE) begin
         if (character == CHAR_NUL) begin
            phase_in = PH_DONE;
         end else if (phase_ff == PH_WS && is_space(character)) begin
            bumps = 2'd1;
         end else begin
            // open the width window at the first non-space character
            if (phase_ff == PH_WS) begin
               limited_in = (cfg.field_width != '0);
               width_left_in = cfg.space_counts_in_width ?
                  room[FWIDTH_W-1:0] : cfg.field_width;
            end
            if (limited_in) begin
               if (width_left_in == '0) begin
                  phase_in = PH_DONE;
                  stop = 1'b1;
               end else begin
                  width_left_in = width_left_in - 1'b1;
               end
            end
            // outer sign
            if (!stop && phase_in == PH_WS) begin
               if (character == CHAR_PLUS || character == CHAR_MINUS) begin
                  negative_in = (character == CHAR_MINUS);
                  bumps = 2'd1;
                  phase_in = PH_POST_SIGN;
                  stop = 1'b1;
               end else begin
                  phase_in = PH_LEAD;
               end
            end
            // space after the outer sign
            if (!stop && phase_in == PH_POST_SIGN) begin
               if (is_space(character) && !cfg.allow_space_after_sign) begin
                  failed_in = 1'b1;
                  phase_in = PH_DONE;
                  stop = 1'b1;
               end else begin
                  phase_in = PH_LEAD;
               end
            end
            // leading space and inner sign
            if (!stop && phase_in == PH_LEAD) begin
               if (is_space(character)) begin
                  bumps = 2'd1;
                  stop = 1'b1;
               end else if (character == CHAR_PLUS || character == CHAR_MINUS) begin
                  inner_neg_in = (character == CHAR_MINUS);
                  bumps = 2'd1;
                  phase_in = PH_PREFIX;
                  stop = 1'b1;
               end else begin
                  phase_in = PH_PREFIX;
               end
            end
            // leading zero of a possible prefix
            if (!stop && phase_in == PH_PREFIX) begin
               if (character == CHAR_ZERO && (pbase == BASE_NONE || pbase == BASE_HEX)) begin
                  bumps = 2'd1;
                  digit_seen_in = 1'b1;
                  acc_in = '0;
                  base_in = pbase;
                  phase_in = PH_ZERO;
                  stop = 1'b1;
               end else begin
                  base_in = (pbase == BASE_NONE) ? BASE_DEC : pbase;
                  phase_in = PH_DIGITS;
               end
            end
            // x after the zero, the x itself is counted with the next digit
            if (!stop && phase_in == PH_ZERO) begin
               if ((character | CASE_BIT) == CHAR_X) begin
                  base_in = BASE_HEX;
                  phase_in = PH_X;
                  stop = 1'b1;
               end else begin
                  if (base_in == BASE_NONE) begin
                     base_in = BASE_OCT;
                  end
                  phase_in = PH_DIGITS;
               end
            end
            if (!stop && phase_in == PH_X) begin
               if (dig < DIGIT_W'(16)) begin
                  bumps = 2'd1;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_DONE;
                  stop = 1'b1;
               end
            end
            // digit accumulate by shift and add, saturating
            if (!stop && phase_in == PH_DIGITS) begin
               if (base_in == BASE_NONE || DIGIT_W'(base_in) <= dig) begin
                  phase_in = PH_DONE;
               end else begin
                  case (base_in)
                     BASE_OCT: mac = {acc_in, 3'b000} + MAC_W'(dig);
                     BASE_HEX: mac = {acc_in, 4'b0000} + MAC_W'(dig);
                     default:  mac = {acc_in, 3'b000} + {acc_in, 1'b0} + MAC_W'(dig);
                  endcase
                  if (!ovf_in) begin
                     if (mac[MAC_W-1:VALUE_W] != '0) begin
                        ovf_in = 1'b1;
                        acc_in = '1;
                     end else begin
                        acc_in = mac[VALUE_W-1:0];
                     end
                  end
                  bumps = bumps + 2'd1;
                  digit_seen_in = 1'b1;
               end
            end
         end
      end
      count_sum = {1'b0, count_ff} + (COUNT_BITS + 1)'(bumps);
      count_in  = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
   end

   // result of a field closed by this character
   always_comb begin
      bad_sign = negative_in &&
         (cfg.conversion_mode == MODE_UNSIGNED_DEC ||
          ((cfg.conversion_mode == MODE_OCTAL || cfg.conversion_mode == MODE_HEX) &&
           !cfg.allow_negative_hex_octal));
      ok = digit_seen_in && !failed_in && !bad_sign;
      count_out_ext = CMP_W'(count_in);
      rsp_value_in = '0;
      if (ovf_in) begin
         rsp_value_in = negative_in ? VALUE_W'(1) : '1;
      end else if (inner_neg_in ^ negative_in) begin
         rsp_value_in = '0 - acc_in;
      end else begin
         rsp_value_in = acc_in;
      end
      if (!ok) begin
         rsp_value_in = '0;
      end
      rsp_count_in   = ok ? count_out_ext[CONSUMED_W-1:0] : '0;
      rsp_success_in = ok;
   end

   // parse state, cleared after the closing character
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff      <= PH_WS;
         negative_ff   <= 1'b0;
         inner_neg_ff  <= 1'b0;
         base_ff       <= BASE_NONE;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         digit_seen_ff <= 1'b0;
         count_ff      <= '0;
         width_left_ff <= '0;
         failed_ff     <= 1'b0;
         limited_ff    <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         inner_neg_ff  <= inner_neg_in;
         base_ff       <= base_in;
         acc_ff        <= acc_in;
         ovf_ff        <= ovf_in;
         digit_seen_ff <= digit_seen_in;
         count_ff      <= count_in;
         width_left_ff <= width_left_in;
         failed_ff     <= failed_in;
         limited_ff    <= limited_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && last) begin
         rsp_value_ff   <= rsp_value_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_success_ff <= rsp_success_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_success = rsp_success_ff;

endmodule

// File: hw/rtl/ascii_integer_scanner.sv
// ascii integer scanner top level: input register, configuration and parser
//
// Characters stream in on the req_ channel, one item per character, with
// req_tlast on the final character of a text field. The block parses one
// integer per field, strtoul style, and returns one item on the rsp_ channel
// for each field: rsp_tdata carries the value and the consumed count,
// rsp_tuser the success flag. Non-final characters produce no item.
// The final character is held in the input register, which feeds the parse
// logic; the parse logic loads the result register when that character
// steps, which it does not do while an older result is still held.
// Throughput: one character per cycle while no final character waits; the
// character step is a single shift-and-add on the 64-bit accumulator between
// the input register and the parse state registers.
// When rsp_tready is low the result register holds; characters keep
// flowing until the next final character reaches the input register, which
// then waits for the result register to drain.
// Reset (synchronous) clears the configuration and the valid flags to zero and
// the parse to its start. The csr_ port writes one register per cycle, used while idle.
module ascii_integer_scanner
   import acis_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // character items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] character
   input  logic                   req_tlast,
   // result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [79:0]            rsp_tdata,   // [63:0] result_value, [79:64] consumed_count
   output logic                   rsp_tuser    // [0] success
);

   acis_cfg_type           cfg;
   logic                   in_valid_ff;
   logic [CHAR_W-1:0]      in_char_ff;
   logic                   in_last_ff;
   logic                   step;
   logic [VALUE_W-1:0]     rsp_value;
   logic [CONSUMED_W-1:0]  rsp_count;

   acis_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a final character waits only while an older result is still held
   assign step       = in_valid_ff && (!in_last_ff || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata[CHAR_W-1:0];
         in_last_ff <= req_tlast;
      end
   end

   acis_parse #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (step),
      .character   (in_char_ff),
      .last        (in_last_ff),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_value   (rsp_value),
      .rsp_count   (rsp_count),
      .rsp_success (rsp_tuser)
   );

   assign rsp_tdata = {rsp_count, rsp_value};

`ifndef SYNTHESIS
   // a closing character always leaves a result behind
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |=> rsp_tvalid)
      else $error("closing character produced no result");

   // the input side stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a held result");

   // a failed parse reports zero value and count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("failed result carries nonzero payload");
`endif

endmodule
